@@ rtl/rfpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rfpd_pkg: shared types and constants of the radio frame parser
// Parse phases, result kinds, radio modes, event codes and register map.
// ----------------------------------------------------------------------------
package rfpd_pkg;

	// Parse phase, one-hot
	typedef enum logic [3:0] {
		PH_WAIT = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_TYPE = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

	// Result kinds (travel on tuser)
	localparam logic [2:0] KIND_OTHER = 3'd0;
	localparam logic [2:0] KIND_REG   = 3'd1;
	localparam logic [2:0] KIND_TX    = 3'd2;
	localparam logic [2:0] KIND_RX    = 3'd3;
	localparam logic [2:0] KIND_EVENT = 3'd4;

	// Radio modes
	localparam logic [1:0] MODE_INIT   = 2'd0;
	localparam logic [1:0] MODE_READY  = 2'd1;
	localparam logic [1:0] MODE_ONLINE = 2'd2;

	// Event codes carried in payload byte 0
	localparam logic [7:0] EV_READY   = 8'ha0;
	localparam logic [7:0] EV_ONLINE  = 8'ha3;
	localparam logic [7:0] EV_READY_B = 8'ha4;
	localparam logic [7:0] EV_READY_C = 8'ha5;

	// Register map, word index (byte address / 4)
	localparam int          ADDR_W     = 5;
	localparam logic [2:0]  REG_START  = 3'd0;
	localparam logic [2:0]  REG_REGREP = 3'd1;
	localparam logic [2:0]  REG_TXREP  = 3'd2;
	localparam logic [2:0]  REG_RXDATA = 3'd3;
	localparam logic [2:0]  REG_EVENT  = 3'd4;

	// Register reset values
	localparam logic [7:0] RST_START  = 8'd251;
	localparam logic [7:0] RST_REGREP = 8'd26;
	localparam logic [7:0] RST_TXREP  = 8'd21;
	localparam logic [7:0] RST_RXDATA = 8'd38;
	localparam logic [7:0] RST_EVENT  = 8'd40;

	// Result data packing
	localparam int OUT_BITS = 98;
	localparam int OUT_W    = 104;

endpackage
`default_nettype wire

@@ rtl/radio_frame_parser_dispatch.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// radio_frame_parser_dispatch: framed packet parser for a radio serial link
// Takes one received byte per beat, tracks start/length/type framing, keeps
// the first payload bytes and dispatches each finished frame by type.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one received byte per beat in s_axis_tdata.
//   m_axis: one result beat per input beat. m_axis_tlast is high when the
//   byte closed a frame with payload, m_axis_tuser gives its kind, and
//   m_axis_tdata carries the type, reply data and the radio state as it
//   stands after that byte.
//   APB: five 8-bit registers at byte addresses 0x00..0x10 (start byte and
//   the four packet type codes); write them only while the block is idle.
// Timing:
//   A result beat is registered and appears in the cycle after its input
//   beat is taken. Without a stall, one byte per cycle is taken: the whole
//   frame update is a single pass of logic between the state registers and
//   the result register. If the receiver stalls, the result register holds
//   its beat and s_axis_tready drops until that beat is taken.
// Reset:
//   arst_n clears the parser to wait for a start byte, clears stored
//   payload and radio state, and loads the default type codes.
// ----------------------------------------------------------------------------
module radio_frame_parser_dispatch
	import rfpd_pkg::*;
#(
	parameter int KEPT_BYTES = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
	// result stream
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// [7:0] frame_type, [39:8] reply_data, [47:40] tx_status,
	// [55:48] tx_rssi, [57:56] radio_mode, [65:58] network_id,
	// [89:66] base_mac, [97:90] network_range, [103:98] zero
	output logic [OUT_W-1:0]          m_axis_tdata,
	output logic                      m_axis_tlast,   // frame_done
	output logic [2:0]                m_axis_tuser,   // [2:0] frame_kind
	// configuration
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int IDX_W = $clog2(KEPT_BYTES + 1);

	// configuration registers
	logic [7:0] start_q, regrep_q, txrep_q, rxdata_q, event_q;
	logic       cfg_wr;
	logic [2:0] cfg_idx;

	// parser state
	phase_t     phase_q, phase_d;
	logic [7:0] left_q, left_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0] pay_q [KEPT_BYTES];
	logic [7:0] pay_d [KEPT_BYTES];
	logic [7:0] type_q, type_d;
	logic [1:0] mode_q, mode_d;
	logic [7:0] status_q, status_d;
	logic [7:0] rssi_q, rssi_d;
	logic [7:0] netid_q, netid_d;
	logic [23:0] mac_q, mac_d;
	logic [7:0] range_q, range_d;

	// per-beat result
	logic        done;
	logic [2:0]  kind;
	logic [31:0] data;
	logic [7:0]  b;

	// result register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             out_last_q;
	logic [2:0]       out_kind_q;

	logic in_fire;

	assign b       = s_axis_tdata;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	// APB access
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_START:  prdata = {24'd0, start_q};
			REG_REGREP: prdata = {24'd0, regrep_q};
			REG_TXREP:  prdata = {24'd0, txrep_q};
			REG_RXDATA: prdata = {24'd0, rxdata_q};
			REG_EVENT:  prdata = {24'd0, event_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= RST_START;
			regrep_q <= RST_REGREP;
			txrep_q  <= RST_TXREP;
			rxdata_q <= RST_RXDATA;
			event_q  <= RST_EVENT;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_START:  start_q  <= pwdata[7:0];
				REG_REGREP: regrep_q <= pwdata[7:0];
				REG_TXREP:  txrep_q  <= pwdata[7:0];
				REG_RXDATA: rxdata_q <= pwdata[7:0];
				REG_EVENT:  event_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// framing, payload capture and dispatch for one byte
	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		idx_d    = idx_q;
		pay_d    = pay_q;
		type_d   = type_q;
		mode_d   = mode_q;
		status_d = status_q;
		rssi_d   = rssi_q;
		netid_d  = netid_q;
		mac_d    = mac_q;
		range_d  = range_q;
		done     = 1'b0;
		kind     = KIND_OTHER;
		data     = 32'd0;

		case (phase_q)
			PH_WAIT: begin
				if (b == start_q) phase_d = PH_LEN;
			end
			PH_LEN: begin
				if (b != 8'd0) begin
					left_d  = b;
					phase_d = PH_TYPE;
				end else begin
					phase_d = PH_WAIT;
				end
			end
			PH_TYPE: begin
				type_d  = b;
				left_d  = left_q - 8'd1;
				idx_d   = '0;
				phase_d = (left_d == 8'd0) ? PH_WAIT : PH_DATA;
			end
			PH_DATA: begin
				// bytes past the kept window are counted only
				if (idx_q < IDX_W'(KEPT_BYTES)) begin
					for (int i = 0; i < KEPT_BYTES; i++) begin
						if (idx_q == IDX_W'(i)) pay_d[i] = b;
					end
					idx_d = idx_q + IDX_W'(1);
				end
				left_d = left_q - 8'd1;
				if (left_d == 8'd0) begin
					phase_d = PH_WAIT;
					idx_d   = '0;
					done    = 1'b1;
				end
			end
			default: phase_d = PH_WAIT;
		endcase

		// dispatch; first matching code wins
		if (done) begin
			if (type_d == regrep_q) begin
				kind = KIND_REG;
				data = {pay_d[3], pay_d[2], pay_d[1], pay_d[0]};
			end else if (type_d == txrep_q) begin
				kind     = KIND_TX;
				status_d = pay_d[0];
				rssi_d   = pay_d[4];
			end else if (type_d == rxdata_q) begin
				kind = KIND_RX;
				data = {16'd0, pay_d[5], pay_d[4]};
			end else if (type_d == event_q) begin
				kind = KIND_EVENT;
				if (pay_d[0] == EV_READY || pay_d[0] == EV_READY_B ||
					pay_d[0] == EV_READY_C) begin
					mode_d = MODE_READY;
				end else if (pay_d[0] == EV_ONLINE) begin
					netid_d = pay_d[1];
					mac_d   = {pay_d[2], pay_d[3], pay_d[4]};
					range_d = pay_d[5];
					mode_d  = MODE_ONLINE;
				end
			end
		end
	end

	// state update on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			left_q   <= 8'd0;
			idx_q    <= '0;
			for (int i = 0; i < KEPT_BYTES; i++) pay_q[i] <= 8'd0;
			type_q   <= 8'd0;
			mode_q   <= MODE_INIT;
			status_q <= 8'd0;
			rssi_q   <= 8'd0;
			netid_q  <= 8'd0;
			mac_q    <= 24'd0;
			range_q  <= 8'd0;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			idx_q    <= idx_d;
			pay_q    <= pay_d;
			type_q   <= type_d;
			mode_q   <= mode_d;
			status_q <= status_d;
			rssi_q   <= rssi_d;
			netid_q  <= netid_d;
			mac_q    <= mac_d;
			range_q  <= range_d;
		end
	end

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_last_q <= done;
			out_kind_q <= kind;
			out_data_q <= {{(OUT_W - OUT_BITS){1'b0}}, range_d, mac_d, netid_d, mode_d,
				rssi_d, status_d, data, type_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_kind_q;

`ifndef SYNTH
	// no byte is taken while a stalled result is still held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted over a stalled result");

	// every accepted byte yields a result beat in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted byte produced no result");

	// payload index never runs past the kept window
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(KEPT_BYTES))
		else $error("payload index out of range");

	// data phase always has bytes left to count
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (left_q != 8'd0))
		else $error("data phase with zero bytes left");

	// a result that closes no frame carries no kind
	a_kind_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_last_q) |-> (out_kind_q == KIND_OTHER))
		else $error("frame kind set without a finished frame");
`endif

endmodule
`default_nettype wire

@@ verif/radio_frame_parser_dispatch_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radio_frame_parser_dispatch_tb: self-checking bench for the frame parser
// Feeds received bytes over the input stream with bursty timing while the
// result side stalls on its own pattern. Every accepted byte runs through a
// behavioral copy of the parser, and each result beat is compared field by
// field. A short directed table comes first. It is followed by register
// phases of random framed traffic, some of it noise or truncated frames.
// ----------------------------------------------------------------------------
module radio_frame_parser_dispatch_tb;
	import rfpd_pkg::*;

	localparam int         KEPT        = 6;
	localparam int         PHASES      = 8;
	localparam int         PHASE_ITEMS = 195;
	localparam logic [2:0] REG_UNUSED  = 3'd5;

	// expected result of one byte
	typedef struct packed {
		logic        done;
		logic [2:0]  kind;
		logic [7:0]  ftype;
		logic [31:0] reply;
		logic [7:0]  status;
		logic [7:0]  rssi;
		logic [1:0]  mode;
		logic [7:0]  netid;
		logic [23:0] mac;
		logic [7:0]  net_range;
	} beat_t;

	// one byte to send; pinned rows carry typed done/kind/reply
	typedef struct packed {
		logic [7:0]  b;
		logic        pin;
		logic        done;
		logic [2:0]  kind;
		logic [31:0] reply;
	} stim_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = 8'd0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              m_axis_tlast;
	logic [2:0]        m_axis_tuser;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = 32'd0;
	logic [31:0]       prdata;
	logic              pready;

	radio_frame_parser_dispatch #(.KEPT_BYTES(KEPT)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// parser copy: configuration and state
	logic [7:0] cfg_start, cfg_reg_code, cfg_tx_code, cfg_rx_code, cfg_ev_code;
	phase_t     prs_phase;
	logic [7:0] prs_left;
	logic [2:0] prs_idx;
	logic [7:0] prs_kept [KEPT];
	logic [7:0] type_q, status_q, rssi_q, netid_q, range_q;
	logic [1:0] mode_q;
	logic [23:0] mac_q;

	stim_item_t byte_fifo [$];
	stim_item_t in_flight;
	beat_t      expected_beats [$];
	int         queued_total = 0;
	int         checked_total = 0;
	int         mismatch_count = 0;
	int         burst_left = 1;
	int         gap_left = 0;
	logic [15:0] stall_pat = 16'hffff;
	int         stall_pos = 0;

	// directed table: zero length, length one, then one frame of
	// each kind; the event reuses nothing, the rx frame reuses event payload
	stim_item_t dir_rows [27] = '{
		'{8'hfb, 1'b1, 1'b0, KIND_OTHER, 32'd0},
		'{8'h00, 1'b1, 1'b0, KIND_OTHER, 32'd0},
		'{8'hfb, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h01, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'hff, 1'b1, 1'b0, KIND_OTHER, 32'd0},
		'{8'hfb, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h03, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h1a, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'hff, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h00, 1'b1, 1'b1, KIND_REG,   32'h0000_00ff},
		'{8'hfb, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h02, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h15, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'hff, 1'b1, 1'b1, KIND_TX,    32'd0},
		'{8'hfb, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h07, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h28, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'ha3, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h01, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h02, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h03, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h04, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'hff, 1'b1, 1'b1, KIND_EVENT, 32'd0},
		'{8'hfb, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h02, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'h26, 1'b0, 1'b0, KIND_OTHER, 32'd0},
		'{8'hfb, 1'b1, 1'b1, KIND_RX,    32'h0000_ff04}
	};

	task automatic clear_parser();
		cfg_start = RST_START;
		cfg_reg_code = RST_REGREP;
		cfg_tx_code = RST_TXREP;
		cfg_rx_code = RST_RXDATA;
		cfg_ev_code = RST_EVENT;
		prs_phase = PH_WAIT;
		prs_left = 8'd0;
		prs_idx = 3'd0;
		for (int i = 0; i < KEPT; i++) prs_kept[i] = 8'd0;
		type_q = 8'd0;
		mode_q = MODE_INIT;
		status_q = 8'd0;
		rssi_q = 8'd0;
		netid_q = 8'd0;
		mac_q = 24'd0;
		range_q = 8'd0;
	endtask

	// advance the parser copy by one byte and build its result
	task automatic parse_byte(input logic [7:0] b, output beat_t res);
		logic        done;
		logic [2:0]  kind;
		logic [31:0] reply;
		done = 1'b0;
		kind = KIND_OTHER;
		reply = 32'd0;
		case (prs_phase)
			PH_WAIT: begin
				if (b == cfg_start) prs_phase = PH_LEN;
			end
			PH_LEN: begin
				if (b != 8'd0) begin
					prs_left = b;
					prs_phase = PH_TYPE;
				end else begin
					prs_phase = PH_WAIT;
				end
			end
			PH_TYPE: begin
				type_q = b;
				prs_left = prs_left - 8'd1;
				prs_idx = 3'd0;
				prs_phase = (prs_left == 8'd0) ? PH_WAIT : PH_DATA;
			end
			default: begin
				if (prs_idx < 3'(KEPT)) begin
					prs_kept[prs_idx] = b;
					prs_idx = prs_idx + 3'd1;
				end
				prs_left = prs_left - 8'd1;
				if (prs_left == 8'd0) begin
					prs_phase = PH_WAIT;
					prs_idx = 3'd0;
					done = 1'b1;
				end
			end
		endcase

		// dispatch in priority order when codes collide
		if (done) begin
			if (type_q == cfg_reg_code) begin
				kind = KIND_REG;
				reply = {prs_kept[3], prs_kept[2], prs_kept[1], prs_kept[0]};
			end else if (type_q == cfg_tx_code) begin
				kind = KIND_TX;
				status_q = prs_kept[0];
				rssi_q = prs_kept[4];
			end else if (type_q == cfg_rx_code) begin
				kind = KIND_RX;
				reply = {16'd0, prs_kept[5], prs_kept[4]};
			end else if (type_q == cfg_ev_code) begin
				kind = KIND_EVENT;
				if (prs_kept[0] == EV_READY || prs_kept[0] == EV_READY_B ||
				    prs_kept[0] == EV_READY_C) begin
					mode_q = MODE_READY;
				end else if (prs_kept[0] == EV_ONLINE) begin
					netid_q = prs_kept[1];
					mac_q = {prs_kept[2], prs_kept[3], prs_kept[4]};
					range_q = prs_kept[5];
					mode_q = MODE_ONLINE;
				end
			end
		end

		res = '{done, kind, type_q, reply, status_q, rssi_q, mode_q, netid_q,
			mac_q, range_q};
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// input side: bursts of beats with random gaps
	always @(posedge clk) begin : byte_sender
		beat_t res;
		logic  took;
		took = s_axis_tvalid && s_axis_tready;
		if (took) begin
			parse_byte(in_flight.b, res);
			if (in_flight.pin) begin
				res.done = in_flight.done;
				res.kind = in_flight.kind;
				res.reply = in_flight.reply;
			end
			expected_beats.push_back(res);
		end
		if (!s_axis_tvalid || took) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (byte_fifo.size() > 0) begin
				in_flight = byte_fifo.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= in_flight.b;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result side: compare each beat, stall on a rotating pattern
	always @(posedge clk) begin : result_check
		beat_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				$error("result beat arrived with nothing expected");
				mismatch_count++;
			end else begin
				want = expected_beats.pop_front();
				check_field("frame_done", 32'(want.done), 32'(m_axis_tlast));
				check_field("frame_kind", 32'(want.kind), 32'(m_axis_tuser));
				check_field("frame_type", 32'(want.ftype), 32'(m_axis_tdata[7:0]));
				check_field("reply_data", want.reply, m_axis_tdata[39:8]);
				check_field("tx_status", 32'(want.status), 32'(m_axis_tdata[47:40]));
				check_field("tx_rssi", 32'(want.rssi), 32'(m_axis_tdata[55:48]));
				check_field("radio_mode", 32'(want.mode), 32'(m_axis_tdata[57:56]));
				check_field("network_id", 32'(want.netid), 32'(m_axis_tdata[65:58]));
				check_field("base_mac", 32'(want.mac), 32'(m_axis_tdata[89:66]));
				check_field("network_range", 32'(want.net_range),
					32'(m_axis_tdata[97:90]));
				check_field("tdata_pad", 32'd0, 32'(m_axis_tdata[OUT_W-1:OUT_BITS]));
				checked_total++;
			end
		end
		if (stall_pos == 0) begin
			stall_pat = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
			if (stall_pat == 16'd0) stall_pat = 16'd1;
		end
		m_axis_tready <= stall_pat[stall_pos[3:0]];
		stall_pos = (stall_pos + 1) % 16;
	end

	task automatic push_byte(input logic [7:0] b);
		stim_item_t it;
		it = '{b, 1'b0, 1'b0, KIND_OTHER, 32'd0};
		byte_fifo.push_back(it);
		queued_total++;
	endtask

	// one framed packet with random content, now and then cut short
	task automatic queue_frame(output int n);
		logic [7:0] body [$];
		int         len;
		int         r;
		int         cut;
		body = {};
		r = $urandom_range(0, 99);
		if (r < 3) len = 0;
		else if (r < 10) len = 1;
		else if (r < 92) len = $urandom_range(2, 9);
		else if (r < 98) len = $urandom_range(10, 40);
		else len = $urandom_range(200, 255);
		body.push_back(cfg_start);
		body.push_back(len[7:0]);
		if (len > 0) begin
			case ($urandom_range(0, 5))
				0: body.push_back(cfg_reg_code);
				1: body.push_back(cfg_tx_code);
				2: body.push_back(cfg_rx_code);
				3: body.push_back(cfg_ev_code);
				default: body.push_back(8'($urandom));
			endcase
		end
		for (int i = 1; i < len; i++) begin
			if (i == 1) begin
				case ($urandom_range(0, 5))
					0: body.push_back(EV_READY);
					1: body.push_back(EV_ONLINE);
					2: body.push_back(EV_READY_B);
					3: body.push_back(EV_READY_C);
					default: body.push_back(8'($urandom));
				endcase
			end else begin
				body.push_back(8'($urandom));
			end
		end
		cut = body.size();
		if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, body.size());
		for (int i = 0; i < cut; i++) push_byte(body[i]);
		n = cut;
	endtask

	task automatic wait_drained();
		while (checked_total != queued_total) @(posedge clk);
	endtask

	// APB write: setup then access, model updated once it has landed
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_START:  cfg_start = val;
			REG_REGREP: cfg_reg_code = val;
			REG_TXREP:  cfg_tx_code = val;
			REG_RXDATA: cfg_rx_code = val;
			REG_EVENT:  cfg_ev_code = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [7:0] s, input logic [7:0] rg,
			input logic [7:0] tx, input logic [7:0] rx, input logic [7:0] ev);
		write_reg(REG_START, s);
		write_reg(REG_REGREP, rg);
		write_reg(REG_TXREP, tx);
		write_reg(REG_RXDATA, rx);
		write_reg(REG_EVENT, ev);
	endtask

	initial begin : main_seq
		int n;
		int phase_items;
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table under reset settings
		foreach (dir_rows[i]) begin
			byte_fifo.push_back(dir_rows[i]);
			queued_total++;
		end
		wait_drained();

		// random phases, each under its own register settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: ;
				1: write_all(8'h00, 8'h00, 8'hff, 8'h7f, 8'h80);
				2: write_all(8'hff, 8'h5a, 8'h5a, 8'h5a, 8'h5a);
				3: write_all(8'h3c, 8'h11, 8'h11, 8'hee, 8'hee);
				4: begin
					write_all(8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom));
					write_reg(REG_UNUSED, 8'($urandom));
				end
				7: write_all(RST_START, RST_REGREP, RST_TXREP, RST_RXDATA, RST_EVENT);
				default: write_all(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 6) == 0) begin
					repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
				end
				queue_frame(n);
				phase_items += n;
			end
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (expected_beats.size() != 0) mismatch_count++;
		if (mismatch_count == 0) begin
			$display("radio_frame_parser_dispatch regression: pass");
		end else begin
			$display("radio_frame_parser_dispatch regression: fail");
		end
		$finish;
	end

	// hard stop
	initial begin : watchdog
		#1_000_000;
		$display("radio_frame_parser_dispatch regression: fail");
		$finish;
	end

endmodule
